[rtl/core/led_matrix_bitplane_scan_assert.svh]
// Assertion macros for the LED matrix bit-plane scan block.
// Used by the top level only; no other dependencies.
`ifndef LED_MATRIX_BITPLANE_SCAN_ASSERT_SVH
`define LED_MATRIX_BITPLANE_SCAN_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LMBS_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// next-cycle implication
`define LMBS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define LMBS_ASSERT_IMP(label, clk, rst_n, cond, prop, msg)
`define LMBS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif

`endif

[rtl/core/lmbs_pkg.sv]
// Shared constants, types and helpers of the LED matrix bit-plane scan block.
// No dependencies.
`default_nettype none

package lmbs_pkg;

    localparam int COLUMNS     = 16;
    localparam int PLANES      = 8;
    localparam int REPEATS     = 41;
    localparam int FRAMES      = 500;

    localparam int NUM_WEIGHTS = 8;
    localparam int WEIGHT_W    = 17;
    localparam int CFG_INDEX_W = 4;
    localparam int WORD_W      = 32;
    localparam int ON_TIME_W   = 16;
    localparam int PLANE_W     = 3;
    localparam int COLUMN_W    = 4;
    localparam int REPEAT_W    = 6;
    localparam int FRAME_W     = 9;
    localparam int ADDR_W      = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [WORD_W-1:0] SELECT_BASE = 32'h0001_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WEIGHT_PLANE0 = 4'd0,
        REG_WEIGHT_PLANE1 = 4'd1,
        REG_WEIGHT_PLANE2 = 4'd2,
        REG_WEIGHT_PLANE3 = 4'd3,
        REG_WEIGHT_PLANE4 = 4'd4,
        REG_WEIGHT_PLANE5 = 4'd5,
        REG_WEIGHT_PLANE6 = 4'd6,
        REG_WEIGHT_PLANE7 = 4'd7
    } reg_index_t;

    // one scheduled slot, handed from the front to the back
    typedef struct packed {
        logic [WORD_W-1:0]   pixel_word;
        logic [COLUMN_W-1:0] column;
        logic [PLANE_W-1:0]  plane;
        logic [ADDR_W-1:0]   next_address;
    } slot_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [WEIGHT_W-1:0] weight_reset(input int k);
        return WEIGHT_W'(2 << k);
    endfunction

endpackage

`default_nettype wire

[rtl/core/lmbs_if.sv]
// Channel interfaces of the LED matrix bit-plane scan block.
// Depends on lmbs_pkg.
`default_nettype none

interface lmbs_cfg_if import lmbs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [WEIGHT_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface lmbs_pixel_if import lmbs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

interface lmbs_result_if import lmbs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    column_mask;
    logic [WORD_W-1:0]    row_word;
    logic [ON_TIME_W-1:0] on_time;
    logic [PLANE_W-1:0]   plane_index;
    logic [ADDR_W-1:0]    next_address;

    modport source (output valid, output column_mask, output row_word, output on_time,
                    output plane_index, output next_address, input ready);
    modport sink   (input valid, input column_mask, input row_word, input on_time,
                    input plane_index, input next_address, output ready);
endinterface

`default_nettype wire

[rtl/core/lmbs_front.sv]
// Front end: accepts frame words, tags them with the slot counters and
// advances the counters. Depends on lmbs_pkg and lmbs_if.
`default_nettype none

module lmbs_front import lmbs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lmbs_pixel_if.sink  pixel,
    input  wire qstat_t qstat,
    output logic        push,
    output slot_t       push_slot
);

    localparam logic [PLANE_W-1:0]  PLANE_LAST  = PLANE_W'(PLANES - 1);
    localparam logic [COLUMN_W-1:0] COLUMN_LAST = COLUMN_W'(COLUMNS - 1);
    localparam logic [REPEAT_W-1:0] REPEAT_LAST = REPEAT_W'(REPEATS - 1);
    localparam logic [FRAME_W-1:0]  FRAME_LAST  = FRAME_W'(FRAMES - 1);

    logic [PLANE_W-1:0]  plane_reg,  plane_next;
    logic [COLUMN_W-1:0] column_reg, column_next;
    logic [REPEAT_W-1:0] repeat_reg, repeat_next;
    logic [FRAME_W-1:0]  frame_reg,  frame_next;

    assign pixel.ready = !qstat.full;
    assign push        = pixel.valid && pixel.ready;

    // plane first, then column, then repeat, then frame
    always_comb
    begin
        plane_next  = plane_reg;
        column_next = column_reg;
        repeat_next = repeat_reg;
        frame_next  = frame_reg;
        if (plane_reg != PLANE_LAST)
        begin
            plane_next = plane_reg + 1'b1;
        end
        else
        begin
            plane_next = '0;
            if (column_reg != COLUMN_LAST)
            begin
                column_next = column_reg + 1'b1;
            end
            else
            begin
                column_next = '0;
                if (repeat_reg != REPEAT_LAST)
                begin
                    repeat_next = repeat_reg + 1'b1;
                end
                else
                begin
                    repeat_next = '0;
                    frame_next  = (frame_reg == FRAME_LAST) ? '0 : frame_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        push_slot.pixel_word   = pixel.pixel_word;
        push_slot.column       = column_reg;
        push_slot.plane        = plane_reg;
        push_slot.next_address = {frame_next, plane_next, column_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg  <= '0;
            column_reg <= '0;
            repeat_reg <= '0;
            frame_reg  <= '0;
        end
        else if (push)
        begin
            plane_reg  <= plane_next;
            column_reg <= column_next;
            repeat_reg <= repeat_next;
            frame_reg  <= frame_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/lmbs_queue.sv]
// Short slot queue between the front and the back end.
// Depends on lmbs_pkg.
`default_nettype none

module lmbs_queue import lmbs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire slot_t push_slot,
    input  wire logic  pop,
    output slot_t      head,
    output qstat_t     qstat
);

    slot_t                  slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg,  count_next;
    logic                   do_push;
    logic                   do_pop;

    assign qstat.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/lmbs_back.sv]
// Back end: holds the plane weights, forms mask and on-time for each queued
// slot and drives the result register. Depends on lmbs_pkg and lmbs_if.
`default_nettype none

module lmbs_back import lmbs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    lmbs_cfg_if.sink     cfg,
    input  wire slot_t   head,
    input  wire qstat_t  qstat,
    output logic         pop,
    lmbs_result_if.source result
);

    logic [WEIGHT_W-1:0]  weights_reg [NUM_WEIGHTS];
    logic                 valid_reg;
    logic [WORD_W-1:0]    mask_reg,   mask_next;
    logic [WORD_W-1:0]    row_reg;
    logic [ON_TIME_W-1:0] on_time_reg, on_time_next;
    logic [PLANE_W-1:0]   plane_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ON_TIME_W-1:0] half_weight;
    logic                 load;

    assign cfg.ready = 1'b1;

    // refill the result register when empty or when its word is taken
    assign load = !valid_reg || result.ready;
    assign pop  = load && !qstat.empty;

    always_comb
    begin
        half_weight  = weights_reg[head.plane][WEIGHT_W-1:1];
        on_time_next = (half_weight == '0) ? ON_TIME_W'(1) : half_weight;
        mask_next    = ~(SELECT_BASE << head.column);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_WEIGHTS; k++)
            begin
                weights_reg[k] <= weight_reset(k);
            end
        end
        else if (cfg.valid && cfg.ready && (cfg.index <= REG_WEIGHT_PLANE7))
        begin
            weights_reg[cfg.index[PLANE_W-1:0]] <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= !qstat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mask_reg    <= mask_next;
            row_reg     <= head.pixel_word;
            on_time_reg <= on_time_next;
            plane_reg   <= head.plane;
            addr_reg    <= head.next_address;
        end
    end

    assign result.valid        = valid_reg;
    assign result.column_mask  = mask_reg;
    assign result.row_word     = row_reg;
    assign result.on_time      = on_time_reg;
    assign result.plane_index  = plane_reg;
    assign result.next_address = addr_reg;

endmodule

`default_nettype wire

[rtl/core/led_matrix_bitplane_scan.sv]
// Top level of the LED matrix bit-plane scan block.
// Depends on lmbs_pkg, lmbs_if, lmbs_front, lmbs_queue, lmbs_back.
//
// Use:
//   pixel  - frame word fetched from the address given by the previous
//            result's next_address (address 0 for the first slot).
//   result - one word per slot: column mask, row word, on-time, plane and
//            the fetch address of the following slot.
//   cfg    - plane weight writes; index 0..7, other indices are dropped.
//            Always ready. Write only while the block is idle.
// Path: an accepted pixel word is written into the slot queue and moved
// into the result register once that register is free.
// Throughput: one word per cycle while result words are taken, set by the
// front end's counter update and the back end's one-slot result register.
// Stall: the four-entry slot queue keeps accepting while result waits; once
// it is full pixel.ready drops until a result word is taken.
// Reset: slot counters clear to zero, weights return to 2, 4, ... 256,
// queue and result register empty.
`default_nettype none
`include "led_matrix_bitplane_scan_assert.svh"

module led_matrix_bitplane_scan import lmbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    lmbs_cfg_if.sink      cfg,
    lmbs_pixel_if.sink    pixel,
    lmbs_result_if.source result
);

    qstat_t qstat;
    slot_t  push_slot;
    slot_t  head;
    logic   push;
    logic   pop;

    lmbs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .qstat     (qstat),
        .push      (push),
        .push_slot (push_slot)
    );

    lmbs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_slot (push_slot),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    lmbs_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .result (result)
    );

    `LMBS_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, push, !qstat.empty, "accepted word lost")
    `LMBS_ASSERT_IMP(a_no_push_when_full, clk, rst_n, qstat.full, !push, "push into full queue")
    `LMBS_ASSERT_IMP(a_on_time_nonzero, clk, rst_n, result.valid, result.on_time != '0, "zero on-time")
    `LMBS_ASSERT_IMP(a_single_column, clk, rst_n, result.valid, $countones(result.column_mask) == 31, "column mask not one-cold")

endmodule

`default_nettype wire
